// ----- rtl/ipl_pkg.sv -----
// Shared types, codes and default sizes for the indexed point list.
`default_nettype none

package ipl_pkg;

    // Default sizes for the top-level parameters.
    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 32;

    // Fixed field widths on the stream ports.
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int COORD_W = 32;
    localparam int FPOS_W  = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_FIND   = 3'd3,
        OP_GET    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // One result as it leaves the block.
    typedef struct packed {
        status_t              status;
        logic [FPOS_W-1:0]    found_position;
        logic [COORD_W-1:0]   x_out;
        logic [COORD_W-1:0]   y_out;
        logic [COORD_W-1:0]   z_out;
        logic [COUNT_W-1:0]   entry_count;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/ipl_out_reg.sv -----
// Output register that holds one result until the downstream side takes it.
`default_nettype none

module ipl_out_reg
    import ipl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  result_t      res,
    output logic         free,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output result_t      data
);

    logic    valid_reg;
    result_t data_reg;

    // The slot can take a new result when empty or when the held one leaves now.
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/indexed_point_list.sv -----
// Top level of the indexed point list: sequencer, point memory and stream ports.
//
// The block keeps an ordered list of up to CAPACITY points of three coordinates in a
// single-port-read, single-port-write synchronous memory and executes one request at a
// time. Push, pop and insert at the end pass through accept, decode and reply; get adds
// a fetch before the reply. Insert in the middle walks the memory from the top entry
// down to the insert position, one entry per cycle. Find scans from entry 0 upwards,
// one entry per cycle, and stops at the first match. The walk pace is set by the
// memory, which gives one read and one write per cycle. Every request yields exactly
// one response carrying a status and the new count. The next request is taken as soon
// as the sequencer is idle, even while the previous response still waits in the output
// register. Entries are only ever read below the count, so the memory needs no
// clearing after reset.
`default_nettype none

module indexed_point_list
    import ipl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    // Request stream.
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // operation[2:0]
    input  wire logic [2:0]    s_tuser,
    // position[6:0], x_coord[38:7], y_coord[70:39], z_coord[102:71], zero pad[103]
    input  wire logic [103:0]  s_tdata,
    // Response stream.
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // status[1:0]
    output logic [1:0]         m_tuser,
    // found_position[5:0], x_out[37:6], y_out[69:38], z_out[101:70],
    // entry_count[108:102], zero pad[111:109]
    output logic [111:0]       m_tdata
);

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    // Coordinates are held on at most the 32 bits that arrive at the port.
    localparam int STORE_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int MEM_W   = 3 * STORE_W;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_FETCH  = 6'b010000,
        S_REPLY  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pend_reg, pend_next;
    logic               more_reg, more_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;

    // The request being worked on.
    logic [OP_W-1:0]    op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [MEM_W-1:0]   pt_reg;
    result_t            res_reg, res_next;

    // Point memory.
    logic [MEM_W-1:0]   mem [CAPACITY];
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [MEM_W-1:0]   rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [MEM_W-1:0]   wr_data;

    logic               accept;
    logic               out_free;
    logic               out_load;
    result_t            out_res;
    result_t            out_data;

    logic [CMP_W-1:0]   pos_cmp;
    logic [CMP_W-1:0]   count_cmp;
    logic               list_full;
    logic               list_empty;
    logic [IDX_W-1:0]   pos_idx;
    logic [IDX_W-1:0]   count_idx;
    logic [IDX_W-1:0]   last_idx;

    // Returns a stored coordinate as 32 bits, sign-extended from COORD_BITS when the
    // coordinate is narrower than the port.
    function automatic logic [COORD_W-1:0] widen(input logic [STORE_W-1:0] v);
        logic [COORD_W-1:0] w;
        logic               sign;
        sign = (COORD_BITS < COORD_W) ? v[STORE_W-1] : 1'b0;
        for (int k = 0; k < COORD_W; k++)
        begin
            w[k] = (k < STORE_W) ? v[k] : sign;
        end
        return w;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign pos_cmp    = CMP_W'(pos_reg);
    assign count_cmp  = CMP_W'(count_reg);
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);
    // Only used where the position or count is known to lie below CAPACITY.
    assign pos_idx    = IDX_W'(pos_reg);
    assign count_idx  = IDX_W'(count_reg);
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        more_next   = more_reg;
        idx_next    = idx_reg;
        wr_idx_next = wr_idx_reg;
        res_next    = res_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_idx;
        wr_data     = pt_reg;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next        = '0;
                res_next.status = STAT_OK;
                pend_next       = 1'b0;
                more_next       = 1'b1;
                state_next      = S_REPLY;
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (list_full)
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_idx;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (list_empty)
                        begin
                            res_next.status = STAT_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    OP_INSERT:
                    begin
                        if (list_full)
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else if (pos_cmp > count_cmp)
                        begin
                            res_next.status = STAT_MISS;
                        end
                        else if (pos_cmp == count_cmp)
                        begin
                            // Insert at the end is a plain append.
                            wr_en      = 1'b1;
                            wr_addr    = count_idx;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            idx_next   = last_idx;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_FIND:
                    begin
                        if (list_empty)
                        begin
                            res_next.status = STAT_EMPTY;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    OP_GET:
                    begin
                        if (list_empty)
                        begin
                            res_next.status = STAT_EMPTY;
                        end
                        else if (pos_cmp >= count_cmp)
                        begin
                            res_next.status = STAT_MISS;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_idx;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        res_next.status = STAT_MISS;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // Each entry read in the previous cycle moves up by one place.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wr_idx_reg + IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                if (more_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = idx_reg;
                    pend_next   = 1'b1;
                    wr_idx_next = idx_reg;
                    idx_next    = idx_reg - IDX_W'(1);
                    more_next   = (idx_reg != pos_idx);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // The gap is open: drop the new point into it.
                        wr_en      = 1'b1;
                        wr_addr    = pos_idx;
                        wr_data    = pt_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_REPLY;
                    end
                end
            end

            S_SCAN:
            begin
                // The entry read in the previous cycle is compared while the next is read.
                if (pend_reg && (rd_data_reg == pt_reg))
                begin
                    res_next.status         = STAT_OK;
                    res_next.found_position = FPOS_W'(wr_idx_reg);
                    state_next              = S_REPLY;
                end
                else if (more_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = idx_reg;
                    pend_next   = 1'b1;
                    wr_idx_next = idx_reg;
                    idx_next    = idx_reg + IDX_W'(1);
                    more_next   = (idx_reg != last_idx);
                end
                else
                begin
                    res_next.status = STAT_MISS;
                    state_next      = S_REPLY;
                end
            end

            S_FETCH:
            begin
                res_next.x_out = widen(rd_data_reg[STORE_W-1:0]);
                res_next.y_out = widen(rd_data_reg[2*STORE_W-1:STORE_W]);
                res_next.z_out = widen(rd_data_reg[3*STORE_W-1:2*STORE_W]);
                state_next     = S_REPLY;
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_res             = res_reg;
        out_res.entry_count = COUNT_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        wr_idx_reg <= wr_idx_next;
        res_reg    <= res_next;
        if (accept)
        begin
            op_reg  <= s_tuser;
            pos_reg <= s_tdata[6:0];
            pt_reg  <= {STORE_W'(s_tdata[102:71]), STORE_W'(s_tdata[70:39]),
                        STORE_W'(s_tdata[38:7])};
        end
    end

    // Point memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    ipl_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .res      (out_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .data     (out_data)
    );

    assign m_tuser = out_data.status;
    assign m_tdata = {3'b000, out_data.entry_count, out_data.z_out, out_data.y_out,
                      out_data.x_out, out_data.found_position};

endmodule

`default_nettype wire
